>>> design/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned MAX_BLOCKS_DEF    = 64;
  localparam int unsigned HEADER_BYTES_DEF  = 24;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'd65536;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // response status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] user_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic              reused;
  } rsp_t;

endpackage

>>> design/first_fit_block_allocator_core.sv
// First-fit heap block allocator without splitting: table scan sequencer and block table.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    ffba_pkg::req_t  (func, req_size, user_address)
//   out_     out  out_valid / out_ready  ffba_pkg::rsp_t  (status, granted_address, reused)
//   cfg_     in   cfg_valid / cfg_ready  heap_limit, 32 bits
//
// A scan compares one table entry per cycle through the single registered read port.
// After accept, a request passes setup, the table read, the compare, the tail/append step
// when no entry matches, and the response state, which loads the output register.
// An empty table skips the scan; zero-size allocates and null frees go straight to the
// response state. in_ready returns as the result is loaded: one transaction at a time.
// Reset (rst_n low, synchronous) empties the table: block count, heap top and all free
// flags clear, heap_limit returns to 65536. No clearing pass is needed.
// in_ready is high only while the sequencer is idle. A finished result sits in the
// output register until taken; the next transaction is accepted meanwhile, and its result
// waits in the response state if the output register is still occupied.
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ffba_pkg::req_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ffba_pkg::rsp_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffba_pkg::ADDR_W-1:0] cfg_data
);
  import ffba_pkg::*;

  // table index and fill count widths
  localparam int unsigned IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNTW-1:0]   CNT_MAX = CNTW'(MAX_BLOCKS);
  localparam logic [ADDR_W:0]   HDR33   = (ADDR_W+1)'(HEADER_BYTES);
  localparam logic [ADDR_W+1:0] HDR34   = (ADDR_W+2)'(HEADER_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_RESP
  } state_t;

  // block table: {start, bytes}; only entries below count_r are ever compared,
  // so the fill count stands in for a reset of the memory.
  logic [2*ADDR_W-1:0] tbl_mem [MAX_BLOCKS];
  logic [2*ADDR_W-1:0] rd_data_r;
  logic [IDXW-1:0]     rd_addr;
  logic                wr_en;
  logic [IDXW-1:0]     wr_addr;
  logic [2*ADDR_W-1:0] wr_data;

  state_t              state_r, state_nxt;
  logic                func_r, func_nxt;
  logic [ADDR_W-1:0]   size_r, size_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CNTW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [IDXW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                cmp_valid_r, cmp_valid_nxt;
  logic [CNTW-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]   heap_top_r, heap_top_nxt;
  logic [ADDR_W-1:0]   limit_r, limit_nxt;
  logic [MAX_BLOCKS-1:0] free_r, free_nxt;
  rsp_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_data_r, out_data_nxt;

  // shared compare unit and append arithmetic
  logic [ADDR_W-1:0]   rd_start;
  logic [ADDR_W-1:0]   rd_bytes;
  logic [ADDR_W:0]     start_hdr;
  logic                hit;
  logic                last_entry;
  logic [ADDR_W+1:0]   end_sum;
  logic [ADDR_W:0]     top_hdr;
  logic                append_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_start  = rd_data_r[2*ADDR_W-1:ADDR_W];
  assign rd_bytes  = rd_data_r[ADDR_W-1:0];
  assign start_hdr = {1'b0, rd_start} + HDR33;
  // alloc: free and big enough; free: user address matches
  assign hit = cmp_valid_r &&
               ((func_r == FUNC_ALLOC) ? (free_r[cmp_idx_r] && (rd_bytes >= size_r))
                                       : (start_hdr == {1'b0, addr_r}));
  assign last_entry = cmp_valid_r && (CNTW'(cmp_idx_r) == (count_r - CNTW'(1)));

  assign end_sum   = {2'b00, heap_top_r} + {2'b00, size_r} + HDR34;
  assign top_hdr   = {1'b0, heap_top_r} + HDR33;
  assign append_ok = (end_sum <= {2'b00, limit_r}) && (count_r != CNT_MAX);

  assign rd_addr = scan_idx_r[IDXW-1:0];
  assign wr_addr = count_r[IDXW-1:0];
  assign wr_data = {heap_top_r, size_r};

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_valid_nxt = 1'b0;
    count_nxt     = count_r;
    heap_top_nxt  = heap_top_r;
    limit_nxt     = cfg_valid ? cfg_data : limit_r;
    free_nxt      = free_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt     = in_data.func;
          size_nxt     = in_data.req_size;
          addr_nxt     = in_data.user_address;
          scan_idx_nxt = '0;
          res_nxt      = '{status: ST_OK, granted_address: '0, reused: 1'b0};
          priority if (in_data.func == FUNC_ALLOC && in_data.req_size == '0) begin
            res_nxt.status = ST_FAIL;
            state_nxt      = S_RESP;
          end else if (in_data.func == FUNC_FREE && in_data.user_address == '0) begin
            res_nxt.status = ST_NULL;
            state_nxt      = S_RESP;
          end else if (count_r == '0) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read entry scan_idx, compare entry cmp_idx read in the cycle before
        cmp_valid_nxt = (scan_idx_r < count_r);
        cmp_idx_nxt   = scan_idx_r[IDXW-1:0];
        if (scan_idx_r < count_r) begin
          scan_idx_nxt = scan_idx_r + CNTW'(1);
        end
        priority if (hit) begin
          if (func_r == FUNC_ALLOC) begin
            free_nxt[cmp_idx_r]     = 1'b0;
            res_nxt.granted_address = start_hdr[ADDR_W-1:0];
            res_nxt.reused          = 1'b1;
          end else begin
            free_nxt[cmp_idx_r] = 1'b1;
          end
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_RESP;
        end else if (last_entry) begin
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_TAIL;
        end
      end
      S_TAIL: begin
        if (func_r == FUNC_FREE) begin
          res_nxt.status = ST_CORRUPT;
        end else if (append_ok) begin
          wr_en                   = 1'b1;
          free_nxt[wr_addr]       = 1'b0;
          count_nxt               = count_r + CNTW'(1);
          heap_top_nxt            = end_sum[ADDR_W-1:0];
          res_nxt.granted_address = top_hdr[ADDR_W-1:0];
        end else begin
          res_nxt.status = ST_FAIL;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_valid_r <= 1'b0;
      count_r     <= '0;
      heap_top_r  <= '0;
      limit_r     <= HEAP_LIMIT_RST;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      count_r     <= count_nxt;
      heap_top_r  <= heap_top_nxt;
      limit_r     <= limit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // block table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

endmodule
